// ===== hdl/cvfm_pkg.sv =====
// Shared types, sizes and register codes for the cell voltage fault monitor.
// Depends on nothing; every file of the monitor imports it.

package cvfm_pkg;

   localparam int MONITORS          = 16;
   localparam int CELLS_PER_MONITOR = 12;
   localparam int CELL_COUNT        = MONITORS * CELLS_PER_MONITOR;
   localparam int CELL_AW           = $clog2(CELL_COUNT);

   typedef logic [3:0]         mon_type;
   typedef logic [3:0]         cell_type;
   typedef logic [15:0]        volt_type;
   typedef logic [31:0]        tick_type;
   typedef logic [15:0]        persist_type;
   typedef logic [11:0]        mask_type;
   typedef logic [CELL_AW-1:0] addr_type;
   typedef logic [2:0]         csr_idx_type;
   typedef logic [15:0]        csr_data_type;

   // Configuration register indexes.
   localparam csr_idx_type REG_OVER_LIMIT     = 3'd0;
   localparam csr_idx_type REG_UNDER_LIMIT    = 3'd1;
   localparam csr_idx_type REG_PERSIST_MS     = 3'd2;
   localparam csr_idx_type REG_MASK_REGULAR   = 3'd3;
   localparam csr_idx_type REG_MASK_ALTERNATE = 3'd4;

   // Reset values of the configuration registers.
   localparam volt_type    OVER_LIMIT_RST     = 16'd42000;
   localparam volt_type    UNDER_LIMIT_RST    = 16'd30000;
   localparam persist_type PERSIST_MS_RST     = 16'd500;
   localparam mask_type    MASK_REGULAR_RST   = 12'd2015;
   localparam mask_type    MASK_ALTERNATE_RST = 12'd975;

   // One accepted sample waiting in the compute stage.
   typedef struct packed {
      addr_type cell_addr;
      cell_type cell_pos;
      logic     in_range;
      logic     alt_mask;
      volt_type volt;
      tick_type now;
      logic     last;
   } stage_type;

   // Monitors whose index leaves a remainder of one when divided by three.
   function automatic logic is_alt_monitor(input mon_type mon);
      return mon inside {4'd1, 4'd4, 4'd7, 4'd10, 4'd13};
   endfunction

   // True when both indexes address an existing cell.
   function automatic logic cell_in_range(input mon_type mon, input cell_type cell_idx);
      return (32'(mon) < MONITORS) && (32'(cell_idx) < CELLS_PER_MONITOR);
   endfunction

   // Flat cell address mon * 12 + cell_idx, built from shifts.
   function automatic addr_type cell_address(input mon_type mon, input cell_type cell_idx);
      logic [8:0] sum;
      sum = {2'b00, mon, 3'b000} + {3'b000, mon, 2'b00} + {5'b00000, cell_idx};
      return sum[CELL_AW-1:0];
   endfunction

endpackage

// ===== hdl/cell_voltage_fault_monitor_top.sv =====
// Top level of the cell voltage fault monitor: stamp memories, compute stage,
// result register and configuration registers. Depends on cvfm_pkg.

// The monitor takes one cell voltage sample per transaction and answers each
// with exactly one result transaction, in order. Throughput is one transaction
// per clock: a sample is accepted in the cycle after the previous one as long
// as the result side is not stalled. Each sample passes the compute stage
// register, then the result register: the accepting edge registers it and
// reads the per-cell time stamps from the two 192-entry stamp memories; a later
// edge, once the result register is free, registers the result and writes back
// the refreshed stamps. Back-to-back samples for the same cell are handled by
// forwarding the stamp written at the acceptance edge. After reset the stamp
// memories are cleared to zero by a pass that writes one entry per cycle;
// req_stall is held high until all 192 entries are cleared, and samples are
// taken from then on. The configuration registers are written through the csr_
// channel, which is always ready; they must only be changed while no sample is
// in flight. A write to an index beyond the register list is ignored.

module cell_voltage_fault_monitor_top (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  cvfm_pkg::mon_type     req_monitor_index,
   input  cvfm_pkg::cell_type    req_cell_index,
   input  cvfm_pkg::volt_type    req_cell_voltage,
   input  cvfm_pkg::tick_type    req_now_ms,
   input  logic                  req_last_in_scan,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_cell_over,
   output logic                  rsp_cell_under,
   output logic                  rsp_scan_over,
   output logic                  rsp_scan_under,
   output logic                  rsp_scan_done,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  cvfm_pkg::csr_idx_type  csr_index,
   input  cvfm_pkg::csr_data_type csr_data
);

   import cvfm_pkg::*;

   // Configuration registers.
   volt_type    over_limit_ff;
   volt_type    under_limit_ff;
   persist_type persist_ms_ff;
   mask_type    mask_regular_ff;
   mask_type    mask_alternate_ff;

   // Compute stage and forwarding state.
   logic        s1_valid_ff;
   stage_type   s1_ff;
   stage_type   s1_in;
   logic        over_byp_ff;
   logic        under_byp_ff;
   tick_type    byp_now_ff;
   logic        over_byp_in;
   logic        under_byp_in;

   // Stamp memories and the clearing pass that zeroes them after reset.
   tick_type              over_mem  [CELL_COUNT];
   tick_type              under_mem [CELL_COUNT];
   tick_type              over_rd_ff;
   tick_type              under_rd_ff;
   logic                  clr_active_ff;
   addr_type              clr_addr_ff;

   // Scan flags and result register.
   logic scan_over_ff;
   logic scan_under_ff;
   logic scan_over_in;
   logic scan_under_in;
   logic rsp_valid_ff;
   logic cell_over_ff;
   logic cell_under_ff;
   logic scan_over_out_ff;
   logic scan_under_out_ff;
   logic scan_done_ff;

   // Handshake and compute signals.
   logic     req_accept;
   logic     s1_advance;
   tick_type over_stamp;
   tick_type under_stamp;
   tick_type over_elapsed;
   tick_type under_elapsed;
   logic     over_viol;
   logic     under_viol;
   logic     populated;
   mask_type cell_mask;
   logic     cell_over;
   logic     cell_under;
   logic     over_we;
   logic     under_we;

   // The compute stage moves on whenever the result register is free or
   // drained in this cycle; a new transaction enters whenever it moves on.
   // No transaction enters while the stamp memories are being cleared.
   assign s1_advance = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall  = clr_active_ff || (s1_valid_ff && rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      s1_in.cell_addr = cell_address(req_monitor_index, req_cell_index);
      s1_in.cell_pos  = req_cell_index;
      s1_in.in_range  = cell_in_range(req_monitor_index, req_cell_index);
      s1_in.alt_mask  = is_alt_monitor(req_monitor_index);
      s1_in.volt      = req_cell_voltage;
      s1_in.now       = req_now_ms;
      s1_in.last      = req_last_in_scan;
   end

   // Stamps come from the forwarded write of the previous transaction when it
   // hit the same cell, else from memory.
   always_comb begin
      over_stamp    = over_byp_ff ? byp_now_ff : over_rd_ff;
      under_stamp   = under_byp_ff ? byp_now_ff : under_rd_ff;
      over_elapsed  = s1_ff.now - over_stamp;
      under_elapsed = s1_ff.now - under_stamp;

      cell_mask = s1_ff.alt_mask ? mask_alternate_ff : mask_regular_ff;
      populated = cell_mask[s1_ff.cell_pos];

      over_viol  = s1_ff.volt >= over_limit_ff;
      under_viol = populated && (s1_ff.volt < under_limit_ff);

      // The over stamp is kept while the voltage stays high, faulted or not.
      cell_over  = s1_ff.in_range && over_viol &&
                   (over_elapsed >= {16'h0000, persist_ms_ff});
      cell_under = s1_ff.in_range && under_viol &&
                   (under_elapsed >= {16'h0000, persist_ms_ff});
      over_we    = s1_advance && s1_ff.in_range && !over_viol;
      under_we   = s1_advance && s1_ff.in_range && !under_viol;

      scan_over_in  = scan_over_ff || cell_over;
      scan_under_in = scan_under_ff || cell_under;

      over_byp_in  = over_we && (s1_ff.cell_addr == s1_in.cell_addr);
      under_byp_in = under_we && (s1_ff.cell_addr == s1_in.cell_addr);
   end

   // The clearing pass walks every entry once, one address per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == addr_type'(CELL_COUNT - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         over_mem[clr_addr_ff] <= '0;
      end else if (over_we) begin
         over_mem[s1_ff.cell_addr] <= s1_ff.now;
      end
      if (req_accept) begin
         over_rd_ff <= over_mem[s1_in.cell_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         under_mem[clr_addr_ff] <= '0;
      end else if (under_we) begin
         under_mem[s1_ff.cell_addr] <= s1_ff.now;
      end
      if (req_accept) begin
         under_rd_ff <= under_mem[s1_in.cell_addr];
      end
   end

   // Compute stage register with its forwarding flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         over_byp_ff  <= 1'b0;
         under_byp_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff  <= 1'b1;
         over_byp_ff  <= over_byp_in;
         under_byp_ff <= under_byp_in;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff      <= s1_in;
         byp_now_ff <= s1_ff.now;
      end
   end

   // Scan flags include the current transaction and clear after the last one.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_over_ff  <= 1'b0;
         scan_under_ff <= 1'b0;
      end else if (s1_advance) begin
         scan_over_ff  <= scan_over_in && !s1_ff.last;
         scan_under_ff <= scan_under_in && !s1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         cell_over_ff      <= cell_over;
         cell_under_ff     <= cell_under;
         scan_over_out_ff  <= scan_over_in;
         scan_under_out_ff <= scan_under_in;
         scan_done_ff      <= s1_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_over  = cell_over_ff;
   assign rsp_cell_under = cell_under_ff;
   assign rsp_scan_over  = scan_over_out_ff;
   assign rsp_scan_under = scan_under_out_ff;
   assign rsp_scan_done  = scan_done_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         over_limit_ff     <= OVER_LIMIT_RST;
         under_limit_ff    <= UNDER_LIMIT_RST;
         persist_ms_ff     <= PERSIST_MS_RST;
         mask_regular_ff   <= MASK_REGULAR_RST;
         mask_alternate_ff <= MASK_ALTERNATE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_OVER_LIMIT: begin
               over_limit_ff <= csr_data;
            end
            REG_UNDER_LIMIT: begin
               under_limit_ff <= csr_data;
            end
            REG_PERSIST_MS: begin
               persist_ms_ff <= csr_data;
            end
            REG_MASK_REGULAR: begin
               mask_regular_ff <= csr_data[11:0];
            end
            REG_MASK_ALTERNATE: begin
               mask_alternate_ff <= csr_data[11:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== tb/tb_cell_voltage_fault_monitor_top.sv =====
// Self-checking testbench for cell_voltage_fault_monitor_top: directed samples,
// randomized scans, a clocked driver and result checker, and a predictor of the
// persistence logic. Depends on cvfm_pkg and the monitor RTL only.
`timescale 1ns / 100ps

module tb_cell_voltage_fault_monitor_top;
   import cvfm_pkg::*;

   localparam int          CLOCK_HALF      = 5;
   localparam int          RESET_CYCLES    = 12;
   localparam int          ITEMS_PER_PHASE = 200;
   localparam int          LAST_PHASE      = 5;
   localparam int          SETTLE_CYCLES   = 4;
   localparam int          VOLT_MAX        = 65535;
   localparam int          RUN_LIMIT_NS    = 6_000_000;
   // First register index past the end of the list; writes there are ignored.
   localparam csr_idx_type REG_SPARE_FIRST = 3'd5;

   // How a cell's voltage is steered while it is revisited scan after scan.
   typedef enum int {TREND_OVER, TREND_UNDER, TREND_NORMAL, TREND_WILD} trend_type;

   typedef struct packed {
      mon_type  mon;
      cell_type cell_pos;
      volt_type volt;
      tick_type now;
      logic     last;
   } sample_type;

   typedef struct packed {
      logic cell_over;
      logic cell_under;
      logic scan_over;
      logic scan_under;
      logic scan_done;
   } verdict_type;

   typedef struct packed {
      volt_type    over_limit;
      volt_type    under_limit;
      persist_type persist;
      mask_type    mask_regular;
      mask_type    mask_alternate;
   } limits_type;

   // Every block input starts at a known value.
   logic         clock             = 1'b0;
   logic         reset             = 1'b1;
   logic         req_valid         = 1'b0;
   logic         req_stall;
   mon_type      req_monitor_index = '0;
   cell_type     req_cell_index    = '0;
   volt_type     req_cell_voltage  = '0;
   tick_type     req_now_ms        = '0;
   logic         req_last_in_scan  = 1'b0;
   logic         rsp_valid;
   logic         rsp_stall         = 1'b0;
   logic         rsp_cell_over;
   logic         rsp_cell_under;
   logic         rsp_scan_over;
   logic         rsp_scan_under;
   logic         rsp_scan_done;
   logic         csr_valid         = 1'b0;
   logic         csr_ready;
   csr_idx_type  csr_index         = '0;
   csr_data_type csr_data          = '0;

   cell_voltage_fault_monitor_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_monitor_index (req_monitor_index),
      .req_cell_index    (req_cell_index),
      .req_cell_voltage  (req_cell_voltage),
      .req_now_ms        (req_now_ms),
      .req_last_in_scan  (req_last_in_scan),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_over     (rsp_cell_over),
      .rsp_cell_under    (rsp_cell_under),
      .rsp_scan_over     (rsp_scan_over),
      .rsp_scan_under    (rsp_scan_under),
      .rsp_scan_done     (rsp_scan_done),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   // Predictor copy of the configuration registers, updated on each write
   // transaction the block accepts.
   volt_type    live_over_limit     = OVER_LIMIT_RST;
   volt_type    live_under_limit    = UNDER_LIMIT_RST;
   persist_type live_persist        = PERSIST_MS_RST;
   mask_type    live_mask_regular   = MASK_REGULAR_RST;
   mask_type    live_mask_alternate = MASK_ALTERNATE_RST;

   // Predictor copy of the per-cell stamps and the scan flags.
   tick_type    over_clear_tick  [CELL_COUNT];
   tick_type    under_clear_tick [CELL_COUNT];
   logic        scan_over_seen   = 1'b0;
   logic        scan_under_seen  = 1'b0;

   sample_type  pending_samples[$];     // samples waiting for the driver
   verdict_type expected_verdicts[$];   // predicted results, oldest first
   sample_type  next_sample;
   verdict_type due_verdict;
   logic        req_fired       = 1'b0; // a sample transaction completed at the last edge
   int          csr_write_count = 0;
   int          error_count     = 0;
   int unsigned send_gap        = 0;
   int unsigned send_calm       = 0;
   int unsigned stall_left      = 0;
   int unsigned stall_calm      = 0;

   // Stimulus-side view of the limits and of simulated time.
   limits_type  stim_limits;
   tick_type    ms_now = '0;
   trend_type   cell_trend [CELL_COUNT];

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Reset is held at the start of the run and never again.
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Hard limit on the run in case the block stops producing results.
   initial begin
      #RUN_LIMIT_NS;
      $display("tb_cell_voltage_fault_monitor_top: done, errors");
      $finish;
   end

   // Length of one idle burst, picked at random from three ranges, the shortest most often.
   function automatic int unsigned idle_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) return $urandom_range(1, 3);
      if (pick < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic report_mismatch(input string text);
      error_count++;
      $display("[%0t] mismatch: %s", $time, text);
   endtask

   task automatic compare_field(input string field, input logic got, input logic want);
      if (got !== want)
         report_mismatch($sformatf("%s is %b, predicted %b", field, got, want));
   endtask

   function automatic void apply_register(input csr_idx_type idx, input csr_data_type data);
      case (idx)
         REG_OVER_LIMIT:     live_over_limit     = data;
         REG_UNDER_LIMIT:    live_under_limit    = data;
         REG_PERSIST_MS:     live_persist        = data;
         REG_MASK_REGULAR:   live_mask_regular   = data[11:0];
         REG_MASK_ALTERNATE: live_mask_alternate = data[11:0];
         default: ;
      endcase
   endfunction

   // Works out the result of one sample and advances the stamps and scan flags.
   // An over-voltage sample keeps its stamp, so the elapsed time keeps growing
   // until the voltage drops; the under check only runs on populated cells.
   function automatic verdict_type judge_sample(input sample_type s);
      verdict_type v;
      int unsigned slot;
      mask_type    mask;
      logic        populated;
      v = '0;
      if (s.mon < MONITORS && s.cell_pos < CELLS_PER_MONITOR) begin
         slot      = s.mon * CELLS_PER_MONITOR + s.cell_pos;
         mask      = (s.mon % 3 == 1) ? live_mask_alternate : live_mask_regular;
         populated = mask[s.cell_pos];
         if (s.volt >= live_over_limit &&
             tick_type'(s.now - over_clear_tick[slot]) >= live_persist) begin
            v.cell_over = 1'b1;
         end else if (s.volt < live_over_limit) begin
            over_clear_tick[slot] = s.now;
         end
         if (!populated || s.volt >= live_under_limit)
            under_clear_tick[slot] = s.now;
         else
            v.cell_under = tick_type'(s.now - under_clear_tick[slot]) >= live_persist;
      end
      scan_over_seen  = scan_over_seen | v.cell_over;
      scan_under_seen = scan_under_seen | v.cell_under;
      v.scan_over     = scan_over_seen;
      v.scan_under    = scan_under_seen;
      v.scan_done     = s.last;
      if (s.last) begin
         scan_over_seen  = 1'b0;
         scan_under_seen = 1'b0;
      end
      return v;
   endfunction

   // Checker and predictor feed. Everything is sampled at the rising edge:
   // register writes first, then the result transaction against the oldest
   // prediction, then the sample transaction that produces a new prediction.
   always @(posedge clock) begin
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            apply_register(csr_index, csr_data);
            csr_write_count <= csr_write_count + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch("result transaction with no sample outstanding");
            end else begin
               due_verdict = expected_verdicts.pop_front();
               compare_field("cell_over", rsp_cell_over, due_verdict.cell_over);
               compare_field("cell_under", rsp_cell_under, due_verdict.cell_under);
               compare_field("scan_over", rsp_scan_over, due_verdict.scan_over);
               compare_field("scan_under", rsp_scan_under, due_verdict.scan_under);
               compare_field("scan_done", rsp_scan_done, due_verdict.scan_done);
            end
         end
         if (req_valid && !req_stall)
            expected_verdicts.push_back(judge_sample(sample_type'{req_monitor_index,
               req_cell_index, req_cell_voltage, req_now_ms, req_last_in_scan}));
      end
   end

   // Sample driver. A presented transaction is held until it has been taken;
   // after that the driver either idles for the gap picked at launch or puts
   // the next queued sample on the bus. Calm stretches send back to back.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (send_gap != 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (pending_samples.size() != 0) begin
            next_sample = pending_samples.pop_front();
            req_monitor_index <= next_sample.mon;
            req_cell_index    <= next_sample.cell_pos;
            req_cell_voltage  <= next_sample.volt;
            req_now_ms        <= next_sample.now;
            req_last_in_scan  <= next_sample.last;
            req_valid         <= 1'b1;
            if (send_calm != 0) begin
               send_calm--;
            end else if ($urandom_range(0, 39) == 0) begin
               send_calm = $urandom_range(30, 120);
            end else if ($urandom_range(0, 2) == 0) begin
               send_gap = idle_len();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result-side back-pressure: random stall bursts with calm stretches between.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_calm != 0)
            stall_calm--;
         else if ($urandom_range(0, 49) == 0)
            stall_calm = $urandom_range(50, 200);
         else if ($urandom_range(0, 3) == 0)
            stall_left = idle_len();
      end
   end

   function automatic void push_sample(input mon_type mon, input cell_type cell_pos,
                                       input volt_type volt, input tick_type now,
                                       input logic last);
      pending_samples.push_back(sample_type'{mon, cell_pos, volt, now, last});
   endfunction

   // Voltage for a cell following its trend, clamped to the converter range.
   function automatic volt_type pick_voltage(input trend_type trend);
      int level;
      case (trend)
         TREND_OVER:
            level = int'(stim_limits.over_limit) + int'($urandom_range(0, 300)) - 60;
         TREND_UNDER:
            level = int'(stim_limits.under_limit) - int'($urandom_range(0, 300)) + 60;
         TREND_NORMAL:
            level = (int'(stim_limits.over_limit) + int'(stim_limits.under_limit)) / 2
                    + int'($urandom_range(0, 200)) - 100;
         default:
            level = int'($urandom_range(0, VOLT_MAX));
      endcase
      if (level < 0)
         level = 0;
      else if (level > VOLT_MAX)
         level = VOLT_MAX;
      return volt_type'(level);
   endfunction

   // Queues one scan over one to three consecutive monitors, cell by cell.
   // Some scans are cut short and never flagged last, and now and then a
   // fully random sample is slipped in. Returns the number of samples queued.
   function automatic int queue_scan();
      int          mon_span;
      int          cutoff;
      int          base_mon;
      int          pos;
      int          count;
      int unsigned slot;
      int unsigned pick;
      mon_type     mon;
      pick = $urandom_range(0, 15);
      if (pick == 0)
         ms_now = ms_now + $urandom_range(0, 70000);
      else if (pick == 1)
         ms_now = $urandom;
      else
         ms_now = ms_now + $urandom_range(0, 150);
      mon_span = $urandom_range(1, 3);
      cutoff   = mon_span * CELLS_PER_MONITOR;
      if ($urandom_range(0, 9) == 0)
         cutoff = $urandom_range(0, mon_span * CELLS_PER_MONITOR - 1);
      base_mon = $urandom_range(0, MONITORS - 1);
      count    = 0;
      for (pos = 0; pos < cutoff; pos++) begin
         if ($urandom_range(0, 19) == 0) begin
            push_sample(mon_type'($urandom_range(0, 15)), cell_type'($urandom_range(0, 15)),
                        volt_type'($urandom), tick_type'($urandom),
                        logic'($urandom_range(0, 1)));
            count++;
         end
         mon  = mon_type'((base_mon + pos / CELLS_PER_MONITOR) % MONITORS);
         slot = mon * CELLS_PER_MONITOR + pos % CELLS_PER_MONITOR;
         if ($urandom_range(0, 7) == 0) begin
            pick = $urandom_range(0, 9);
            cell_trend[slot] = pick < 3 ? TREND_OVER : pick < 6 ? TREND_UNDER :
                               pick < 9 ? TREND_NORMAL : TREND_WILD;
         end
         ms_now = ms_now + $urandom_range(0, 2);
         push_sample(mon, cell_type'(pos % CELLS_PER_MONITOR), pick_voltage(cell_trend[slot]),
                     ms_now, pos == mon_span * CELLS_PER_MONITOR - 1);
         count++;
      end
      return count;
   endfunction

   // Blocks until every queued sample is sent and every result has arrived,
   // then lets the pipeline settle.
   task automatic wait_drained();
      while (pending_samples.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One register write transaction; returns once the block has taken it.
   // Consecutive calls keep csr_valid high from one transaction to the next.
   task automatic write_register(input csr_idx_type idx, input csr_data_type data);
      int seen;
      seen = csr_write_count;
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      wait (csr_write_count != seen);
   endtask

   // Writes all five limits, plus one write past the end of the register list.
   // Mask writes carry random upper bits that the block must drop.
   task automatic program_limits(input limits_type lim, input int phase);
      write_register(csr_idx_type'(REG_SPARE_FIRST + phase % 3), csr_data_type'($urandom));
      write_register(REG_OVER_LIMIT, lim.over_limit);
      write_register(REG_UNDER_LIMIT, lim.under_limit);
      write_register(REG_PERSIST_MS, lim.persist);
      write_register(REG_MASK_REGULAR, {4'($urandom_range(0, 15)), lim.mask_regular});
      write_register(REG_MASK_ALTERNATE, {4'($urandom_range(0, 15)), lim.mask_alternate});
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Random scans for one phase, with one full drain halfway through so the
   // sender is seen pausing until nothing is outstanding.
   task automatic queue_random(input int total);
      int queued;
      logic paused;
      queued = 0;
      paused = 1'b0;
      while (queued < total) begin
         if (!paused && queued >= total / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         queued += queue_scan();
      end
   endtask

   // Hand-picked samples under the reset limits (over 42000, under 30000,
   // persistence 500 ms, regular mask 0x7DF, alternate mask 0x3CF).
   function automatic void queue_directed();
      // Under-voltage timing from a never-written stamp: one short, then exact.
      push_sample(4'd0, 4'd0, 16'd0, 32'd0, 1'b0);
      push_sample(4'd0, 4'd0, 16'd0, 32'd499, 1'b0);
      push_sample(4'd0, 4'd0, 16'd0, 32'd500, 1'b1);
      // Over-voltage at full scale on the last monitor and cell.
      push_sample(4'd15, 4'd11, 16'hFFFF, 32'd0, 1'b0);
      push_sample(4'd15, 4'd11, 16'hFFFF, 32'd500, 1'b0);
      // Just below the over limit refreshes the stamp; exactly at it restarts timing.
      push_sample(4'd15, 4'd11, 16'd41999, 32'd600, 1'b0);
      push_sample(4'd15, 4'd11, 16'd42000, 32'd1099, 1'b1);
      // Unpopulated cells on a regular and an alternate monitor never go under.
      push_sample(4'd0, 4'd5, 16'd0, 32'd2000, 1'b0);
      push_sample(4'd1, 4'd4, 16'd0, 32'd2000, 1'b0);
      push_sample(4'd13, 4'd10, 16'd0, 32'd2000, 1'b0);
      // Populated alternate cell just under the limit, then exactly at it.
      push_sample(4'd1, 4'd0, 16'd29999, 32'd2000, 1'b0);
      push_sample(4'd1, 4'd0, 16'd30000, 32'd2001, 1'b0);
      push_sample(4'd2, 4'd10, 16'd0, 32'd3000, 1'b0);
      push_sample(4'd7, 4'd9, 16'd100, 32'd3000, 1'b0);
      // Cell positions past the end touch nothing; the last one still ends the scan.
      push_sample(4'd3, 4'd12, 16'd0, 32'd3000, 1'b0);
      push_sample(4'd9, 4'd15, 16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      // Elapsed time across the tick wrap: 499 ms, then exactly 500 ms.
      push_sample(4'd6, 4'd3, 16'd100, 32'hFFFF_FF00, 1'b0);
      push_sample(4'd6, 4'd3, 16'hFFFF, 32'h0000_00F3, 1'b0);
      push_sample(4'd6, 4'd3, 16'hFFFF, 32'h0000_00F4, 1'b1);
      push_sample(4'd10, 4'd6, 16'h5555, 32'hAAAA_AAAA, 1'b0);
      push_sample(4'd5, 4'd7, 16'hAAAA, 32'h5555_5555, 1'b1);
   endfunction

   // Limits per phase: two opposite extremes, a narrow band with short
   // persistence, a random set, and the reset values written back.
   function automatic limits_type choose_limits(input int phase);
      limits_type lim;
      case (phase)
         1: lim = '{16'd0, 16'hFFFF, 16'd0, 12'hFFF, 12'h000};
         2: lim = '{16'hFFFF, 16'd0, 16'hFFFF, 12'h000, 12'hFFF};
         3: lim = '{16'd40000, 16'd33000, 16'd40, mask_type'($urandom), mask_type'($urandom)};
         4: begin
            lim.over_limit     = volt_type'($urandom_range(20000, VOLT_MAX));
            lim.under_limit    = volt_type'($urandom_range(0, lim.over_limit));
            lim.persist        = persist_type'($urandom_range(0, 2000));
            lim.mask_regular   = mask_type'($urandom);
            lim.mask_alternate = mask_type'($urandom);
         end
         default: lim = '{OVER_LIMIT_RST, UNDER_LIMIT_RST, PERSIST_MS_RST,
                          MASK_REGULAR_RST, MASK_ALTERNATE_RST};
      endcase
      return lim;
   endfunction

   // Test sequence: directed samples under the reset limits, then one random
   // phase per setting. Limits change only once the block has gone idle.
   initial begin
      int phase;
      foreach (over_clear_tick[k]) begin
         over_clear_tick[k]  = '0;
         under_clear_tick[k] = '0;
         cell_trend[k]       = TREND_NORMAL;
      end
      stim_limits = '{OVER_LIMIT_RST, UNDER_LIMIT_RST, PERSIST_MS_RST,
                      MASK_REGULAR_RST, MASK_ALTERNATE_RST};
      wait (!reset);
      queue_directed();
      for (phase = 0; phase <= LAST_PHASE; phase++) begin
         if (phase != 0) begin
            wait_drained();
            stim_limits = choose_limits(phase);
            program_limits(stim_limits, phase);
         end
         // One phase starts just short of the tick wrap.
         if (phase == 3)
            ms_now = 32'hFFFF_F000;
         queue_random(ITEMS_PER_PHASE);
      end
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_cell_voltage_fault_monitor_top: done, clean");
      else
         $display("tb_cell_voltage_fault_monitor_top: done, errors");
      $finish;
   end

endmodule
